/* rtl/core/lba_to_chs_disk_command_assert.svh */
// Assertion macros shared by the translation pipeline files.
`ifndef LBA_TO_CHS_DISK_COMMAND_ASSERT_SVH
`define LBA_TO_CHS_DISK_COMMAND_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define LBACHS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define LBACHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lbachs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lbachs_pkg;

  localparam int LBA_W     = 24;
  localparam int HEAD_W    = 9;
  localparam int SPT_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPT        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SEL  = 2'd2;

  localparam logic [7:0] OP_READ    = 8'h02;
  localparam logic [7:0] OP_WRITE   = 8'h03;
  localparam logic [7:0] DRIVE_BASE = 8'h80;

  typedef struct packed {
    logic             command;
    logic [LBA_W-1:0] lba;
    logic [7:0]       sector_count;
    logic [19:0]      dma_address;
  } in_t;

  typedef struct packed {
    logic [15:0] function_word;
    logic [15:0] cyl_sector_word;
    logic [15:0] head_drive_word;
    logic [3:0]  buffer_offset;
    logic [15:0] buffer_segment;
    logic        out_of_range;
  } out_t;

  // Fields that ride alongside the first division.
  typedef struct packed {
    logic        command;
    logic [7:0]  sector_count;
    logic [19:0] dma_address;
  } side1_t;

  // Fields that ride alongside the second division.
  typedef struct packed {
    side1_t           base;
    logic [SPT_W-1:0] sector;
  } side2_t;

endpackage

`default_nettype wire

/* rtl/core/lba_to_chs_disk_command.sv */
// Linear sector to cylinder/head/sector command builder.
// Input channel: one transfer descriptor per beat on in_data, taken when
// in_valid is high and in_stall is low. Output channel: one packed command
// per input beat on out_data, taken when out_valid is high and out_stall
// is low. Each cfg_ write sets head count, sectors per track or drive
// select, chosen by cfg_index; write it only while no beats are in flight.
// From input acceptance to out_valid, six stages divide the sector number
// by sectors per track and six more divide the quotient by the head count,
// four quotient bits per stage, then one output register. Throughput is
// one beat per cycle while the receiver does not stall.
// Synchronous reset empties the pipeline and loads geometry defaults of
// 1 head, 63 sectors per track and drive 0. When the receiver stalls, the
// output beat holds, bubbles inside the pipeline close up, and in_stall
// rises only once every stage holds a beat.
`timescale 1ns / 1ps
`default_nettype none

`include "lba_to_chs_disk_command_assert.svh"

module lba_to_chs_disk_command
  import lbachs_pkg::*;
#(
  parameter int MAX_DRIVE_COUNT = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_t                      out_data
);

  localparam logic [7:0] DRIVE_MAX = 8'(MAX_DRIVE_COUNT - 1);

  logic [HEAD_W-1:0] head_cnt_r;
  logic [SPT_W-1:0]  spt_r;
  logic              drive_sel_r;
  logic [HEAD_W-1:0] heads_eff;
  logic [SPT_W-1:0]  spt_eff;
  logic [7:0]        drive_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_cnt_r  <= HEAD_W'(1);
      spt_r       <= SPT_W'(63);
      drive_sel_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAD_COUNT: head_cnt_r  <= cfg_wdata;
        CFG_SPT:        spt_r       <= cfg_wdata[SPT_W-1:0];
        CFG_DRIVE_SEL:  drive_sel_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // A zero geometry value counts as one.
  assign heads_eff = (head_cnt_r == '0) ? HEAD_W'(1) : head_cnt_r;
  assign spt_eff   = (spt_r == '0) ? SPT_W'(1) : spt_r;
  assign drive_eff = (32'(drive_sel_r) >= MAX_DRIVE_COUNT) ? DRIVE_MAX
                                                           : {7'd0, drive_sel_r};

  side1_t             side1_in;
  logic               div1_in_ready;
  logic               div1_valid;
  logic [LBA_W-1:0]   div1_quot;
  logic [SPT_W-1:0]   div1_rem;
  logic [$bits(side1_t)-1:0] div1_side;
  side2_t             side2_in;
  logic               div2_in_ready;
  logic               div2_valid;
  logic               div2_ready;
  logic [LBA_W-1:0]   div2_quot;
  logic [HEAD_W-1:0]  div2_rem;
  logic [$bits(side2_t)-1:0] div2_side;
  side2_t             side2_out;

  assign side1_in.command      = in_data.command;
  assign side1_in.sector_count = in_data.sector_count;
  assign side1_in.dma_address  = in_data.dma_address;

  lbachs_div_pipe #(
    .NW  (LBA_W),
    .DW  (SPT_W),
    .BPS (4),
    .SW  ($bits(side1_t))
  ) u_div_spt (
    .clk         (clk),
    .rst_n       (rst_n),
    .divisor     (spt_eff),
    .in_valid    (in_valid),
    .in_ready    (div1_in_ready),
    .in_dividend (in_data.lba),
    .in_side     (side1_in),
    .out_valid   (div1_valid),
    .out_ready   (div2_in_ready),
    .out_quot    (div1_quot),
    .out_rem     (div1_rem),
    .out_side    (div1_side)
  );

  // The remainder stays below sectors per track, so the 1-based sector fits.
  assign side2_in.base   = side1_t'(div1_side);
  assign side2_in.sector = div1_rem + SPT_W'(1);

  lbachs_div_pipe #(
    .NW  (LBA_W),
    .DW  (HEAD_W),
    .BPS (4),
    .SW  ($bits(side2_t))
  ) u_div_head (
    .clk         (clk),
    .rst_n       (rst_n),
    .divisor     (heads_eff),
    .in_valid    (div1_valid),
    .in_ready    (div2_in_ready),
    .in_dividend (div1_quot),
    .in_side     (side2_in),
    .out_valid   (div2_valid),
    .out_ready   (div2_ready),
    .out_quot    (div2_quot),
    .out_rem     (div2_rem),
    .out_side    (div2_side)
  );

  assign side2_out = side2_t'(div2_side);

  out_t out_r;
  out_t out_nxt;
  logic out_valid_r;

  always_comb begin
    out_nxt.function_word   = {side2_out.base.command ? OP_WRITE : OP_READ,
                               side2_out.base.sector_count};
    out_nxt.cyl_sector_word = {div2_quot[7:0], div2_quot[9:8], side2_out.sector};
    out_nxt.head_drive_word = {div2_rem[7:0], DRIVE_BASE + drive_eff};
    out_nxt.buffer_offset   = side2_out.base.dma_address[3:0];
    out_nxt.buffer_segment  = side2_out.base.dma_address[19:4];
    out_nxt.out_of_range    = |div2_quot[LBA_W-1:10];
  end

  assign div2_ready = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div2_ready) begin
      out_valid_r <= div2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div2_ready && div2_valid) begin
      out_r <= out_nxt;
    end
  end

  assign in_stall  = ~div1_in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `LBACHS_ASSERT_NOW(a_op_code, clk, rst_n, out_valid_r, out_r.function_word[15:9] == 7'h01, "function code is neither read nor write")
  `LBACHS_ASSERT_NOW(a_drive_code, clk, rst_n, out_valid_r, out_r.head_drive_word[7] == 1'b1, "drive code lost its hard disk bit")
  `LBACHS_ASSERT_NEXT(a_out_drains, clk, rst_n, out_valid_r && !out_stall && !div2_valid, !out_valid_r, "taken beat was repeated")

endmodule

`default_nettype wire

/* rtl/core/lbachs_div_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "lba_to_chs_disk_command_assert.svh"

module lbachs_div_pipe #(
  parameter int NW  = 24,
  parameter int DW  = 6,
  parameter int BPS = 4,
  parameter int SW  = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [DW-1:0] divisor,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [NW-1:0] in_dividend,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [NW-1:0]      out_quot,
  output logic [DW-1:0]      out_rem,
  output logic [SW-1:0]      out_side
);

  localparam int STAGES = NW / BPS;

  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] vld_src;
  logic [STAGES:0]   stage_rdy;
  logic [DW-1:0]     rem_r    [STAGES];
  logic [NW-1:0]     acc_r    [STAGES];
  logic [SW-1:0]     side_r   [STAGES];
  logic [DW-1:0]     rem_nxt  [STAGES];
  logic [NW-1:0]     acc_nxt  [STAGES];
  logic [SW-1:0]     side_nxt [STAGES];

  // Restoring division, BPS quotient bits. The accumulator shifts dividend
  // bits out at the top and quotient bits in at the bottom.
  function automatic logic [DW+NW-1:0] div_steps(logic [DW-1:0] r, logic [NW-1:0] a,
                                                 logic [DW-1:0] d);
    logic [DW:0] t;
    for (int i = 0; i < BPS; i++) begin
      t = {r, a[NW-1]};
      a = {a[NW-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t    = t - {1'b0, d};
        a[0] = 1'b1;
      end
      r = t[DW-1:0];
    end
    return {r, a};
  endfunction

  assign stage_rdy[STAGES] = out_ready;
  for (genvar k = 0; k < STAGES; k++) begin : g_rdy
    assign stage_rdy[k] = ~valid_r[k] | stage_rdy[k+1];
  end

  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      if (k == 0) begin
        vld_src[k]                = in_valid;
        {rem_nxt[k], acc_nxt[k]}  = div_steps('0, in_dividend, divisor);
        side_nxt[k]               = in_side;
      end else begin
        vld_src[k]                = valid_r[k-1];
        {rem_nxt[k], acc_nxt[k]}  = div_steps(rem_r[k-1], acc_r[k-1], divisor);
        side_nxt[k]               = side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (stage_rdy[k]) begin
          valid_r[k] <= vld_src[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (stage_rdy[k] && vld_src[k]) begin
        rem_r[k]  <= rem_nxt[k];
        acc_r[k]  <= acc_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign in_ready  = stage_rdy[0];
  assign out_valid = valid_r[STAGES-1];
  assign out_quot  = acc_r[STAGES-1];
  assign out_rem   = rem_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

  `LBACHS_ASSERT_NEXT(a_entry_lands, clk, rst_n, in_valid && in_ready, valid_r[0], "accepted beat did not land in the first stage")
  `LBACHS_ASSERT_NOW(a_empty_takes, clk, rst_n, !valid_r[0], in_ready, "empty first stage refused a beat")
  `LBACHS_ASSERT_NEXT(a_last_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_quot), "held final stage lost its beat")

endmodule

`default_nettype wire
